// File: rtl/jaac_pkg.sv
// Joystick axis autocalibration: shared widths, constants, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
package jaac_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 4;
  localparam int NUM_W       = 16;
  localparam int SCALE_SHIFT = 7;
  localparam int DIV_STEPS   = NUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int REG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [SAMPLE_W-1:0] CENTER_VALUE  = 8'd128;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 8'd255;
  localparam logic [CAP_W-1:0]    CAPTURE_RESET = 4'd10;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_REMAP_ENABLE  = 1'd0;
  localparam reg_idx_t REG_CAPTURE_INDEX = 1'd1;

  typedef struct packed {
    logic load_sample;
    logic update_state;
    logic div_load;
    logic div_step;
    logic load_out;
  } jaac_cmd_t;

  typedef struct packed {
    logic remap_enable;
    logic out_free;
  } jaac_status_t;

endpackage

// File: rtl/jaac_div.sv
// Restoring divider, one quotient bit per step (16-bit by 8-bit).
// Depends on jaac_pkg.
module jaac_div
  import jaac_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  logic [NUM_W-1:0]    num,
  input  logic [SAMPLE_W-1:0] den,
  output logic [NUM_W-1:0]    quo
);

  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] den_q;
  logic [SAMPLE_W:0]   shifted;
  logic [SAMPLE_W+1:0] trial;

  assign shifted = {rem, quo[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (step) begin
      if (!trial[SAMPLE_W+1]) begin
        rem <= trial[SAMPLE_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[SAMPLE_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/jaac_datapath.sv
// Datapath: config registers, sample/counter/min/center/max state, per-axis
// dividers, result scaling and the output register. Depends on jaac_pkg, jaac_div.
module jaac_datapath
  import jaac_pkg::*;
#(
  parameter int AXIS_COUNT = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  jaac_cmd_t                      cmd,
  output jaac_status_t                   status,
  input  logic                           cfg_valid,
  input  reg_idx_t                       cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic [AXIS_COUNT*SAMPLE_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [AXIS_COUNT*SAMPLE_W-1:0] m_tdata
);

  logic                           remap_enable;
  logic [CAP_W-1:0]               capture_index;
  logic [COUNT_W-1:0]             count;
  logic [COUNT_W-1:0]             count_inc;
  logic [COUNT_W-1:0]             count_next;
  logic                           capture;
  logic                           bypass;
  logic [AXIS_COUNT*SAMPLE_W-1:0] smp;
  logic [AXIS_COUNT*SAMPLE_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_enable  <= 1'b0;
      capture_index <= CAPTURE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REMAP_ENABLE:  remap_enable  <= cfg_data[0];
        REG_CAPTURE_INDEX: capture_index <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // count up to the capture index, capture once, then park at index + 1
  always_comb begin
    count_inc  = (count < {1'b0, capture_index}) ? count + 1'b1 : count;
    capture    = (count_inc == {1'b0, capture_index});
    count_next = capture ? {1'b0, capture_index} + 1'b1 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.update_state) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      smp    <= s_tdata;
      bypass <= !remap_enable;
    end
  end

  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] den;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    quo;
    logic                above;
    logic                below;
    logic                above_w;
    logic                below_w;
    logic [SAMPLE_W-1:0] scaled;

    assign v = smp[a*SAMPLE_W +: SAMPLE_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        lo  <= CENTER_VALUE;
        mid <= CENTER_VALUE;
        hi  <= CENTER_VALUE;
      end else if (cmd.update_state) begin
        if (capture) begin
          mid <= v;
        end
        if (v < lo) begin
          lo <= v;
        end else if (v > hi) begin
          hi <= v;
        end
      end
    end

    // numerator is ceiling-biased below center so the result floors
    always_comb begin
      above_w = (v > mid);
      below_w = (v < mid);
      diff    = above_w ? v - mid : mid - v;
      den     = above_w ? hi - mid : mid - lo;
      num     = {{(NUM_W-SAMPLE_W-SCALE_SHIFT){1'b0}}, diff, {SCALE_SHIFT{1'b0}}};
      if (!above_w) begin
        num = num + {{(NUM_W-SAMPLE_W){1'b0}}, den} - 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.div_load) begin
        above <= above_w;
        below <= below_w;
      end
    end

    jaac_div u_div (
      .clk  (clk),
      .load (cmd.div_load),
      .step (cmd.div_step),
      .num  (num),
      .den  (den),
      .quo  (quo)
    );

    always_comb begin
      if (bypass) begin
        scaled = v;
      end else if (above) begin
        scaled = (quo > NUM_W'(CENTER_VALUE - 1'b1)) ? FULL_SCALE
                                                     : {1'b1, quo[SAMPLE_W-2:0]};
      end else if (below) begin
        scaled = (quo > NUM_W'(CENTER_VALUE)) ? '0
                 : SAMPLE_W'({1'b0, CENTER_VALUE} - {1'b0, quo[SAMPLE_W-1:0]});
      end else begin
        scaled = CENTER_VALUE;
      end
    end

    assign result[a*SAMPLE_W +: SAMPLE_W] = scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= result;
    end
  end

  assign status.remap_enable = remap_enable;
  assign status.out_free     = !m_tvalid || m_tready;

endmodule

// File: rtl/jaac_ctrl.sv
// Controller: sequences accept, state update, divider load, divide steps
// and output load. Depends on jaac_pkg.
module jaac_ctrl
  import jaac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  jaac_status_t status,
  output jaac_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] iter;
  logic [STEP_W-1:0] iter_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    iter_next  = iter;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_sample = 1'b1;
          state_next      = status.remap_enable ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: begin
        cmd.update_state = 1'b1;
        state_next       = ST_START;
      end
      ST_START: begin
        cmd.div_load = 1'b1;
        iter_next    = '0;
        state_next   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 1'b1;
        if (iter == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule

// File: rtl/joystick_axis_autocalibrate_top.sv
// Joystick axis autocalibration: input stream in, rescaled stream out.
// Usage:
//   s_tdata carries one 8-bit sample per axis (axis 0 in the low byte).
//   m_tdata carries one 8-bit calibrated value per axis in the same order.
//   cfg channel: index 0 = remap_enable, index 1 = center_capture_index;
//   cfg_ready is always high, write only while no item is in flight.
// Sequence with remapping on: input transfer, state update, divider load,
//   16 divide steps, output load, then m_tvalid; with remapping off the output
//   load follows the input transfer with no state update or division. One item
//   is worked on at a time, so a new item is accepted only once the last one's
//   result is loaded; the 16-step restoring divider runs in parallel on every axis.
// The output register decouples the sides: the next item is accepted and
//   computed while a result waits; a stalled receiver holds m_tdata and
//   only blocks the following result from loading.
// Reset (rst, synchronous): min/center/max return to 128, sample count to 0,
//   remap_enable to 0, capture index to 10, output empty.
// Depends on jaac_pkg, jaac_ctrl, jaac_datapath, jaac_div.
module joystick_axis_autocalibrate_top
  import jaac_pkg::*;
#(
  parameter int AXIS_COUNT = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [AXIS_COUNT*SAMPLE_W-1:0] s_tdata,   // x_sample, y_sample, ...
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [AXIS_COUNT*SAMPLE_W-1:0] m_tdata,   // x_scaled, y_scaled, ...
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  reg_idx_t                       cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  jaac_cmd_t    cmd;
  jaac_status_t status;

  assign cfg_ready = 1'b1;

  jaac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  jaac_datapath #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: rtl/jaac_checker.sv
// Port-level checks for the joystick autocalibration top, bound to it.
// Depends on jaac_pkg.
module jaac_checker
  import jaac_pkg::*;
#(
  parameter int AXIS_COUNT = 2
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [AXIS_COUNT*SAMPLE_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second item while busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an item in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind joystick_axis_autocalibrate_top jaac_checker #(
  .AXIS_COUNT (AXIS_COUNT)
) u_jaac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
